>>> rtl/core/mqw_pkg.sv
// shared constants for the message queue with priority waiter lists
package mqw_pkg;

  localparam int DEF_QUEUE_DEPTH       = 16;
  localparam int DEF_MAX_TASKS         = 16;
  localparam int DEF_MESSAGE_MAX_BYTES = 8;
  localparam int RES_LIMIT             = 16;

  localparam logic [2:0] FUNC_SEND    = 3'd0;
  localparam logic [2:0] FUNC_RECV    = 3'd1;
  localparam logic [2:0] FUNC_PEEK    = 3'd2;
  localparam logic [2:0] FUNC_REMOVE  = 3'd3;
  localparam logic [2:0] FUNC_FLUSH   = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_BLOCKED = 2'd3;

  localparam logic CFG_MSG_BYTES = 1'b0;
  localparam logic CFG_CAPACITY  = 1'b1;

  localparam logic [3:0] RST_MSG_BYTES = 4'd4;
  localparam logic [4:0] RST_CAPACITY  = 5'd16;

  localparam logic LIST_SEND = 1'b0;
  localparam logic LIST_RECV = 1'b1;

endpackage

>>> rtl/core/message_queue_with_priority_waiters.sv
// top level: rtos message queue with priority-sorted sender and receiver waiter lists
//
// channel  direction  handshake                 payload
// in_      input      start high, busy low      func, message, task, priorities, timeout, flags
// out_     output     out_valid strobe, 1 cycle status, message, woken task, requests, counts, last
// cfg_     input      cfg_we                    cfg_index selects register, cfg_wdata
//
// send that succeeds: result straight from S_EXEC; receive or peek goes through S_READ (one ram read)
// blocking call: walks the send list, the receive list, then the target list, one entry per cycle
// flush: one result per cycle per woken waiter, up to 16, except while the walk moves
// from the send list to the receive list
// busy stays high until the last result is registered; results cannot be stalled
// reset (synchronous, active low) empties the queue and both waiter lists
module message_queue_with_priority_waiters #(
  parameter int QUEUE_DEPTH       = mqw_pkg::DEF_QUEUE_DEPTH,
  parameter int MAX_TASKS         = mqw_pkg::DEF_MAX_TASKS,
  parameter int MESSAGE_MAX_BYTES = mqw_pkg::DEF_MESSAGE_MAX_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_func,
  input  logic [63:0] in_message,
  input  logic [3:0]  in_task_id,
  input  logic [7:0]  in_task_priority,
  input  logic [15:0] in_timeout_ticks,
  input  logic        in_from_isr,
  input  logic [7:0]  in_running_priority,
  input  logic        in_running_active,
  input  logic        in_waiter_list,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [63:0] out_read_message,
  output logic        out_woken_valid,
  output logic [3:0]  out_woken_task,
  output logic        out_woken_timed_out,
  output logic        out_preempt_request,
  output logic        out_isr_switch_request,
  output logic [15:0] out_block_timeout,
  output logic [4:0]  out_fill_count,
  output logic [4:0]  out_free_spaces,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_wdata
);

  import mqw_pkg::*;

  localparam int PW     = QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1;
  localparam int IW     = $clog2(MAX_TASKS);
  localparam int CW     = $clog2(MAX_TASKS + 1);
  localparam int CAPMAX = QUEUE_DEPTH < 31 ? QUEUE_DEPTH : 31;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_DROP  = 3'd3;
  localparam logic [2:0] S_INS   = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [3:0]    msg_bytes_r;
  logic [4:0]    cap_r;
  logic [PW-1:0] rp_r, rp_nxt, wp_r, wp_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  logic [3:0]    ids_r [2][MAX_TASKS];
  logic [7:0]    pri_r [2][MAX_TASKS];
  logic [CW-1:0] wcnt_r [2];
  logic [CW-1:0] idx_r, idx_nxt;
  logic          sel_r, sel_nxt;
  logic [4:0]    k_r, k_nxt, total_r, total_nxt;
  logic [1:0]    stat_r, stat_nxt;

  // latched transaction
  logic [2:0]  func_r;
  logic [63:0] msg_r;
  logic [3:0]  tid_r;
  logic [7:0]  tpri_r;
  logic [15:0] tmo_r;
  logic        isr_r, runact_r, wl_r;
  logic [7:0]  runp_r;

  logic        accept;
  logic [4:0]  cap_eff;
  logic [3:0]  bytes_eff;
  logic [63:0] mask;

  logic          ram_we, ram_re;
  logic [63:0]   ram_rdata;

  logic          do_rm, rm_sel, do_ins, wake, wake_sel;
  logic [IW-1:0] rm_pos, ins_pos;
  logic          clr_lists;
  logic [CW:0]   wsum;

  logic          emit, e_wv, e_wt_o, e_pre, e_isr, e_last;
  logic [1:0]    e_status;
  logic [63:0]   e_msg;
  logic [3:0]    e_wt;
  logic [15:0]   e_bt;
  logic [4:0]    e_free;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  always_comb begin
    if (cap_r == 5'd0) begin
      cap_eff = 5'd1;
    end else if (int'(cap_r) > CAPMAX) begin
      cap_eff = 5'(CAPMAX);
    end else begin
      cap_eff = cap_r;
    end
    if (msg_bytes_r == 4'd0) begin
      bytes_eff = 4'd1;
    end else if (int'(msg_bytes_r) > MESSAGE_MAX_BYTES) begin
      bytes_eff = 4'(MESSAGE_MAX_BYTES);
    end else begin
      bytes_eff = msg_bytes_r;
    end
    for (int b = 0; b < 8; b++) begin
      mask[b*8 +: 8] = (b < int'(bytes_eff)) ? 8'hff : 8'h00;
    end
  end

  mqw_ram #(
    .WIDTH(64),
    .DEPTH(QUEUE_DEPTH)
  ) u_msg_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wp_r),
    .wdata(msg_r & mask),
    .re   (ram_re),
    .raddr(rp_r),
    .rdata(ram_rdata)
  );

  assign wsum = {1'b0, wcnt_r[0]} + {1'b0, wcnt_r[1]};

  always_comb begin
    state_nxt = state_r;
    rp_nxt    = rp_r;
    wp_nxt    = wp_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    sel_nxt   = sel_r;
    k_nxt     = k_r;
    total_nxt = total_r;
    stat_nxt  = stat_r;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    do_rm     = 1'b0;
    rm_sel    = sel_r;
    rm_pos    = idx_r[IW-1:0];
    do_ins    = 1'b0;
    ins_pos   = idx_r[IW-1:0];
    clr_lists = 1'b0;
    wake      = 1'b0;
    wake_sel  = LIST_RECV;
    emit      = 1'b0;
    e_status  = ST_OK;
    e_msg     = '0;
    e_wv      = 1'b0;
    e_wt      = '0;
    e_wt_o    = 1'b0;
    e_pre     = 1'b0;
    e_isr     = 1'b0;
    e_bt      = '0;
    e_last    = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        idx_nxt = '0;
        case (func_r)
          FUNC_SEND: begin
            if (cnt_r < cap_eff) begin
              ram_we    = 1'b1;
              wp_nxt    = (int'(wp_r) + 1 >= int'(cap_eff)) ? '0 : PW'(int'(wp_r) + 1);
              cnt_nxt   = cnt_r + 5'd1;
              wake      = 1'b1;
              wake_sel  = LIST_RECV;
              emit      = 1'b1;
              state_nxt = S_IDLE;
            end else if (tmo_r != '0 && !isr_r) begin
              stat_nxt  = ST_FULL;
              sel_nxt   = LIST_SEND;
              state_nxt = S_DROP;
            end else begin
              e_status  = ST_FULL;
              emit      = 1'b1;
              state_nxt = S_IDLE;
            end
          end
          FUNC_RECV: begin
            if (cnt_r != 5'd0) begin
              ram_re    = 1'b1;
              state_nxt = S_READ;
            end else if (tmo_r != '0 && !isr_r) begin
              stat_nxt  = ST_EMPTY;
              sel_nxt   = LIST_SEND;
              state_nxt = S_DROP;
            end else begin
              e_status  = ST_EMPTY;
              emit      = 1'b1;
              state_nxt = S_IDLE;
            end
          end
          FUNC_PEEK: begin
            if (cnt_r != 5'd0) begin
              ram_re    = 1'b1;
              state_nxt = S_READ;
            end else begin
              e_status  = ST_EMPTY;
              emit      = 1'b1;
              state_nxt = S_IDLE;
            end
          end
          FUNC_REMOVE: begin
            stat_nxt  = ST_OK;
            sel_nxt   = wl_r;
            state_nxt = S_DROP;
          end
          FUNC_FLUSH: begin
            cnt_nxt = '0;
            rp_nxt  = '0;
            wp_nxt  = '0;
            total_nxt = (int'(wsum) > RES_LIMIT) ? 5'(RES_LIMIT) : 5'(wsum);
            k_nxt   = '0;
            sel_nxt = LIST_SEND;
            if (wsum == '0) begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              state_nxt = S_FLUSH;
            end
          end
          default: begin
            emit      = 1'b1;
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_READ: begin
        e_msg     = ram_rdata & mask;
        emit      = 1'b1;
        state_nxt = S_IDLE;
        if (func_r == FUNC_RECV) begin
          rp_nxt   = (int'(rp_r) + 1 >= int'(cap_eff)) ? '0 : PW'(int'(rp_r) + 1);
          cnt_nxt  = cnt_r - 5'd1;
          wake     = 1'b1;
          wake_sel = LIST_SEND;
        end
      end
      S_DROP: begin
        // walk one entry per cycle looking for the task id
        if (idx_r == wcnt_r[sel_r] || ids_r[sel_r][idx_r[IW-1:0]] == tid_r) begin
          if (idx_r != wcnt_r[sel_r]) begin
            do_rm = 1'b1;
          end
          idx_nxt = '0;
          if (func_r == FUNC_REMOVE) begin
            emit      = 1'b1;
            state_nxt = S_IDLE;
          end else if (sel_r == LIST_SEND) begin
            sel_nxt = LIST_RECV;
          end else begin
            sel_nxt   = (func_r == FUNC_SEND) ? LIST_SEND : LIST_RECV;
            state_nxt = S_INS;
          end
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      S_INS: begin
        if (int'(wcnt_r[sel_r]) >= MAX_TASKS) begin
          e_status  = stat_r;
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end else if (idx_r == wcnt_r[sel_r] || pri_r[sel_r][idx_r[IW-1:0]] > tpri_r) begin
          do_ins    = 1'b1;
          e_status  = ST_BLOCKED;
          e_bt      = tmo_r;
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      S_FLUSH: begin
        if (idx_r < wcnt_r[sel_r]) begin
          emit    = 1'b1;
          e_wv    = 1'b1;
          e_wt_o  = 1'b1;
          e_wt    = ids_r[sel_r][idx_r[IW-1:0]];
          e_last  = (k_r + 5'd1 == total_r);
          k_nxt   = k_r + 5'd1;
          idx_nxt = idx_r + CW'(1);
          if (e_last) begin
            clr_lists = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          sel_nxt = LIST_RECV;
          idx_nxt = '0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // wake the head of the opposite list
    if (wake && wcnt_r[wake_sel] != '0) begin
      e_wv   = 1'b1;
      e_wt   = ids_r[wake_sel][0];
      e_isr  = isr_r;
      e_pre  = !isr_r && runact_r && (pri_r[wake_sel][0] < runp_r);
      do_rm  = 1'b1;
      rm_sel = wake_sel;
      rm_pos = '0;
    end

    e_free = (cnt_nxt >= cap_eff) ? 5'd0 : cap_eff - cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      msg_bytes_r <= RST_MSG_BYTES;
      cap_r       <= RST_CAPACITY;
      rp_r        <= '0;
      wp_r        <= '0;
      cnt_r       <= '0;
      wcnt_r[0]   <= '0;
      wcnt_r[1]   <= '0;
      out_valid   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rp_r      <= rp_nxt;
      wp_r      <= wp_nxt;
      cnt_r     <= cnt_nxt;
      out_valid <= emit;
      if (cfg_we) begin
        if (cfg_index == CFG_MSG_BYTES) begin
          msg_bytes_r <= cfg_wdata[3:0];
        end else begin
          cap_r <= cfg_wdata;
        end
      end
      if (clr_lists) begin
        wcnt_r[0] <= '0;
        wcnt_r[1] <= '0;
      end else if (do_rm) begin
        wcnt_r[rm_sel] <= wcnt_r[rm_sel] - CW'(1);
      end else if (do_ins) begin
        wcnt_r[sel_r] <= wcnt_r[sel_r] + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    sel_r   <= sel_nxt;
    k_r     <= k_nxt;
    total_r <= total_nxt;
    stat_r  <= stat_nxt;
    if (accept) begin
      func_r   <= in_func;
      msg_r    <= in_message;
      tid_r    <= in_task_id;
      tpri_r   <= in_task_priority;
      tmo_r    <= in_timeout_ticks;
      isr_r    <= in_from_isr;
      runp_r   <= in_running_priority;
      runact_r <= in_running_active;
      wl_r     <= in_waiter_list;
    end
    if (do_rm) begin
      for (int j = 0; j < MAX_TASKS - 1; j++) begin
        if (IW'(j) >= rm_pos) begin
          ids_r[rm_sel][j] <= ids_r[rm_sel][j+1];
          pri_r[rm_sel][j] <= pri_r[rm_sel][j+1];
        end
      end
    end else if (do_ins) begin
      for (int j = 1; j < MAX_TASKS; j++) begin
        if (IW'(j) > ins_pos) begin
          ids_r[sel_r][j] <= ids_r[sel_r][j-1];
          pri_r[sel_r][j] <= pri_r[sel_r][j-1];
        end
      end
      ids_r[sel_r][ins_pos] <= tid_r;
      pri_r[sel_r][ins_pos] <= tpri_r;
    end
    out_status             <= e_status;
    out_read_message       <= e_msg;
    out_woken_valid        <= e_wv;
    out_woken_task         <= e_wt;
    out_woken_timed_out    <= e_wt_o;
    out_preempt_request    <= e_pre;
    out_isr_switch_request <= e_isr;
    out_block_timeout      <= e_bt;
    out_fill_count         <= cnt_nxt;
    out_free_spaces        <= e_free;
    out_last               <= e_last;
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_req_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_preempt_request && out_isr_switch_request))
    else $error("preempt and isr switch raised together");

  a_block_tmo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_BLOCKED |-> out_block_timeout != 16'd0)
    else $error("blocked caller with zero timeout");

  a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> cnt_r <= 5'(CAPMAX))
    else $error("message count beyond queue depth");
`endif

endmodule

>>> rtl/core/mqw_ram.sv
// generic single-port-write ram with registered read
module mqw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> test/message_queue_with_priority_waiters_tb.sv
// testbench for the message queue with priority waiter lists
`timescale 1ns / 100ps

module message_queue_with_priority_waiters_tb;
  import mqw_pkg::*;

  typedef struct {
    logic [2:0]  func;
    logic [63:0] message;
    logic [3:0]  task_id;
    logic [7:0]  task_priority;
    logic [15:0] timeout_ticks;
    logic        from_isr;
    logic [7:0]  running_priority;
    logic        running_active;
    logic        waiter_list;
  } call_t;

  typedef struct {
    logic [1:0]  status;
    logic [63:0] read_message;
    logic        woken_valid;
    logic [3:0]  woken_task;
    logic        woken_timed_out;
    logic        preempt_request;
    logic        isr_switch_request;
    logic [15:0] block_timeout;
    logic [4:0]  fill_count;
    logic [4:0]  free_spaces;
    logic        last;
  } reply_t;

  typedef struct {
    logic [3:0] id;
    logic [7:0] prio;
  } waiter_t;

  class mq_scoreboard;
    logic [63:0] store[16];
    bit          written[16];
    int          rd_ptr, wr_ptr, fill;
    waiter_t     send_waiters[$];
    waiter_t     recv_waiters[$];
    int          msg_bytes = RST_MSG_BYTES;
    int          capacity = RST_CAPACITY;
    reply_t      due_replies[$];
    int          errors, replies_seen, wakeups, blocks;

    function int eff_cap();
      if (capacity < 1) return 1;
      if (capacity > DEF_QUEUE_DEPTH) return DEF_QUEUE_DEPTH;
      return capacity;
    endfunction

    function logic [63:0] msg_mask();
      int b;
      b = msg_bytes < 1 ? 1 : (msg_bytes > 8 ? 8 : msg_bytes);
      if (b == 8) return '1;
      return (64'd1 << (8 * b)) - 64'd1;
    endfunction

    function int advance(int p);
      return (p + 1 >= eff_cap()) ? 0 : p + 1;
    endfunction

    function void set_register(logic idx, int value);
      if (idx == CFG_MSG_BYTES) msg_bytes = value & 15;
      else capacity = value & 31;
    endfunction

    // a receive or peek now would read a slot never written
    function bit read_unsafe();
      return fill > 0 && !written[rd_ptr];
    endfunction

    function void push_reply(reply_t r, bit is_last);
      r.fill_count  = 5'(fill);
      r.free_spaces = 5'((fill >= eff_cap()) ? 0 : eff_cap() - fill);
      r.last        = is_last;
      due_replies.push_back(r);
    endfunction

    function void drop_id(ref waiter_t lst[$], logic [3:0] id);
      foreach (lst[i])
        if (lst[i].id == id) begin
          lst.delete(i);
          return;
        end
    endfunction

    function void insert_sorted(ref waiter_t lst[$], waiter_t w);
      int pos;
      pos = 0;
      while (pos < lst.size() && lst[pos].prio <= w.prio) pos++;
      lst.insert(pos, w);
    endfunction

    function void wake_head(ref waiter_t lst[$], ref reply_t r, input call_t c);
      if (lst.size() == 0) return;
      r.woken_valid = 1'b1;
      r.woken_task  = lst[0].id;
      if (c.from_isr) r.isr_switch_request = 1'b1;
      else if (lst[0].prio < c.running_priority && c.running_active) r.preempt_request = 1'b1;
      lst.delete(0);
      wakeups++;
    endfunction

    // works out the replies of one accepted call and queues them
    function void note_call(call_t c);
      reply_t  r;
      waiter_t w;
      waiter_t all[$];
      bit      is_send;
      r = '{default: '0};
      case (c.func)
        FUNC_SEND, FUNC_RECV: begin
          is_send = (c.func == FUNC_SEND);
          if (is_send ? (fill < eff_cap()) : (fill > 0)) begin
            if (is_send) begin
              store[wr_ptr]   = c.message & msg_mask();
              written[wr_ptr] = 1;
              wr_ptr = advance(wr_ptr);
              fill++;
              wake_head(recv_waiters, r, c);
            end else begin
              r.read_message = store[rd_ptr] & msg_mask();
              rd_ptr = advance(rd_ptr);
              fill--;
              wake_head(send_waiters, r, c);
            end
          end else begin
            r.status = is_send ? ST_FULL : ST_EMPTY;
            if (c.timeout_ticks != 0 && !c.from_isr) begin
              drop_id(send_waiters, c.task_id);
              drop_id(recv_waiters, c.task_id);
              w.id = c.task_id;
              w.prio = c.task_priority;
              if (is_send) insert_sorted(send_waiters, w);
              else insert_sorted(recv_waiters, w);
              r.status = ST_BLOCKED;
              r.block_timeout = c.timeout_ticks;
              blocks++;
            end
          end
          push_reply(r, 1);
        end
        FUNC_PEEK: begin
          if (fill == 0) r.status = ST_EMPTY;
          else r.read_message = store[rd_ptr] & msg_mask();
          push_reply(r, 1);
        end
        FUNC_REMOVE: begin
          if (c.waiter_list == LIST_SEND) drop_id(send_waiters, c.task_id);
          else drop_id(recv_waiters, c.task_id);
          push_reply(r, 1);
        end
        FUNC_FLUSH: begin
          all = {send_waiters, recv_waiters};
          send_waiters.delete();
          recv_waiters.delete();
          fill = 0;
          rd_ptr = 0;
          wr_ptr = 0;
          if (all.size() == 0) push_reply(r, 1);
          else begin
            r.woken_valid = 1'b1;
            r.woken_timed_out = 1'b1;
            foreach (all[i]) begin
              r.woken_task = all[i].id;
              push_reply(r, i == all.size() - 1);
            end
          end
        end
        default: push_reply(r, 1);
      endcase
    endfunction

    function void cmp(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: mismatch on %s, expected %h, actual %h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_reply(reply_t a);
      reply_t e;
      replies_seen++;
      if (due_replies.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual status %0d",
                 $time, a.status);
        errors++;
        return;
      end
      e = due_replies.pop_front();
      cmp("status", e.status, a.status);
      cmp("read_message", e.read_message, a.read_message);
      cmp("woken_valid", e.woken_valid, a.woken_valid);
      cmp("woken_task", e.woken_task, a.woken_task);
      cmp("woken_timed_out", e.woken_timed_out, a.woken_timed_out);
      cmp("preempt_request", e.preempt_request, a.preempt_request);
      cmp("isr_switch_request", e.isr_switch_request, a.isr_switch_request);
      cmp("block_timeout", e.block_timeout, a.block_timeout);
      cmp("fill_count", e.fill_count, a.fill_count);
      cmp("free_spaces", e.free_spaces, a.free_spaces);
      cmp("last", e.last, a.last);
    endfunction
  endclass

  logic        clk, rst_n, start, busy;
  logic [2:0]  in_func;
  logic [63:0] in_message;
  logic [3:0]  in_task_id;
  logic [7:0]  in_task_priority, in_running_priority;
  logic [15:0] in_timeout_ticks;
  logic        in_from_isr, in_running_active, in_waiter_list;
  logic        out_valid;
  reply_t      seen;
  logic        cfg_we, cfg_index;
  logic [4:0]  cfg_wdata;

  mq_scoreboard sb = new();
  int           cycles, calls_done;
  bit           no_idle;

  message_queue_with_priority_waiters DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_message(in_message), .in_task_id(in_task_id),
    .in_task_priority(in_task_priority), .in_timeout_ticks(in_timeout_ticks),
    .in_from_isr(in_from_isr), .in_running_priority(in_running_priority),
    .in_running_active(in_running_active), .in_waiter_list(in_waiter_list),
    .out_valid(out_valid), .out_status(seen.status), .out_read_message(seen.read_message),
    .out_woken_valid(seen.woken_valid), .out_woken_task(seen.woken_task),
    .out_woken_timed_out(seen.woken_timed_out), .out_preempt_request(seen.preempt_request),
    .out_isr_switch_request(seen.isr_switch_request),
    .out_block_timeout(seen.block_timeout), .out_fill_count(seen.fill_count),
    .out_free_spaces(seen.free_spaces), .out_last(seen.last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_reply(seen);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb: failure");
      $finish;
    end
  end

  function call_t make_call(logic [2:0] f, logic [63:0] m, logic [3:0] id, logic [7:0] pr,
                            logic [15:0] tmo, logic isr, logic [7:0] runp, logic runact,
                            logic wl);
    call_t c;
    c.func = f; c.message = m; c.task_id = id; c.task_priority = pr;
    c.timeout_ticks = tmo; c.from_isr = isr; c.running_priority = runp;
    c.running_active = runact; c.waiter_list = wl;
    return c;
  endfunction

  // holds start high with the call until the block takes it
  task issue(call_t c);
    if (!no_idle && $urandom_range(0, 99) < 24) begin
      start <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1;
    in_func <= c.func; in_message <= c.message; in_task_id <= c.task_id;
    in_task_priority <= c.task_priority; in_timeout_ticks <= c.timeout_ticks;
    in_from_isr <= c.from_isr; in_running_priority <= c.running_priority;
    in_running_active <= c.running_active; in_waiter_list <= c.waiter_list;
    do @(posedge clk); while (busy);
    sb.note_call(c);
    calls_done++;
  endtask

  task drain();
    start <= 0;
    @(posedge clk);
    while (sb.due_replies.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_reg(logic idx, logic [4:0] value);
    drain();
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_register(idx, value);
  endtask

  function call_t random_call();
    call_t c;
    int    pick;
    pick = $urandom_range(0, 99);
    c.func = pick < 38 ? FUNC_SEND : pick < 70 ? FUNC_RECV : pick < 80 ? FUNC_PEEK :
             pick < 91 ? FUNC_REMOVE : pick < 96 ? FUNC_FLUSH : 3'($urandom_range(5, 7));
    if ((c.func == FUNC_RECV || c.func == FUNC_PEEK) && sb.read_unsafe()) c.func = FUNC_SEND;
    c.message = {$urandom, $urandom};
    c.task_id = 4'($urandom_range(0, 15));
    c.task_priority = 8'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 255));
    c.timeout_ticks = $urandom_range(0, 9) < 3 ? 16'd0 : 16'($urandom);
    c.from_isr = $urandom_range(0, 99) < 15;
    c.running_priority = 8'($urandom_range(0, 255));
    c.running_active = $urandom_range(0, 3) != 0;
    c.waiter_list = 1'($urandom_range(0, 1));
    return c;
  endfunction

  initial begin
    int caps[$] = '{1, 16, 0, 31, 3, 8};
    int sizes[$] = '{8, 1, 0, 15, 2, 5};
    cycles = 0;
    calls_done = 0;
    no_idle = 0;
    rst_n <= 0;
    start <= 0;
    cfg_we <= 0; cfg_index <= CFG_MSG_BYTES; cfg_wdata <= '0;
    in_func <= FUNC_SEND; in_message <= '0; in_task_id <= '0; in_task_priority <= '0;
    in_timeout_ticks <= '0; in_from_isr <= 0; in_running_priority <= '0;
    in_running_active <= 0; in_waiter_list <= 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty queue, waiters with ties, wakeups, remove and flush
    issue(make_call(FUNC_PEEK, '0, 0, 0, 0, 0, 0, 0, 0));
    issue(make_call(FUNC_RECV, '0, 1, 9, 0, 0, 0, 0, 0));
    issue(make_call(FUNC_RECV, '0, 2, 9, 16'hFFFF, 1, 0, 0, 0));
    issue(make_call(FUNC_RECV, '0, 3, 5, 16'd1, 0, 0, 0, 0));
    issue(make_call(FUNC_RECV, '0, 4, 5, 16'd7, 0, 0, 0, 0));
    issue(make_call(FUNC_RECV, '0, 15, 2, 16'hFFFF, 0, 0, 0, 0));
    issue(make_call(FUNC_RECV, '0, 3, 255, 16'd3, 0, 0, 0, 0));
    issue(make_call(FUNC_REMOVE, '0, 4, 0, 0, 0, 0, 0, LIST_RECV));
    issue(make_call(FUNC_REMOVE, '0, 9, 0, 0, 0, 0, 0, LIST_SEND));
    issue(make_call(FUNC_SEND, '1, 7, 0, 0, 1, 0, 1, 0));
    issue(make_call(FUNC_SEND, 64'h0123_4567_89AB_CDEF, 7, 0, 0, 0, 8'd255, 1, 0));
    issue(make_call(FUNC_PEEK, '0, 0, 0, 0, 0, 0, 0, 0));
    issue(make_call(FUNC_RECV, '0, 0, 0, 0, 0, 0, 0, 0));
    issue(make_call(FUNC_RECV, '0, 0, 0, 0, 0, 0, 0, 0));
    issue(make_call(3'd7, '1, 15, 255, 16'hFFFF, 1, 255, 1, 1));
    issue(make_call(3'd5, '0, 0, 0, 0, 0, 0, 0, 0));

    write_reg(CFG_MSG_BYTES, 5'd8);
    write_reg(CFG_CAPACITY, 5'd3);
    issue(make_call(FUNC_SEND, '1, 1, 0, 0, 0, 0, 0, 0));
    issue(make_call(FUNC_SEND, 64'hAAAA_5555_AAAA_5555, 1, 0, 0, 0, 0, 0, 0));
    issue(make_call(FUNC_SEND, 64'h8000_0000_0000_0001, 1, 0, 0, 0, 0, 0, 0));
    issue(make_call(FUNC_SEND, '0, 6, 0, 16'd5, 1, 0, 0, 0));
    issue(make_call(FUNC_SEND, '0, 6, 200, 16'd5, 0, 0, 0, 0));
    issue(make_call(FUNC_SEND, '0, 8, 0, 16'd9, 0, 0, 0, 0));
    // capacity below the fill level: queue reads as full
    write_reg(CFG_CAPACITY, 5'd1);
    issue(make_call(FUNC_RECV, '0, 2, 0, 0, 0, 8'd100, 1, 0));
    issue(make_call(FUNC_RECV, '0, 12, 44, 16'd4, 0, 0, 0, 0));
    issue(make_call(FUNC_FLUSH, '0, 0, 0, 0, 0, 0, 0, 0));
    issue(make_call(FUNC_FLUSH, '0, 0, 0, 0, 0, 0, 0, 0));

    // random traffic across register settings
    for (int i = 0; i < 84; i++) begin
      if (i % 18 == 0) begin
        write_reg(CFG_CAPACITY, 5'(caps[(i / 18) % caps.size()]));
        write_reg(CFG_MSG_BYTES, 5'(sizes[(i / 18) % sizes.size()]));
      end
      no_idle = (i >= 40 && i < 75);
      issue(random_call());
    end

    drain();
    $display("tb: %0d calls, %0d replies checked, %0d wakeups, %0d blocked callers",
             calls_done, sb.replies_seen, sb.wakeups, sb.blocks);
    $display("tb: covered all functions, isr and task callers, several sizes and capacities");
    if (sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

>>> files.f
rtl/core/mqw_pkg.sv
rtl/core/mqw_ram.sv
rtl/core/message_queue_with_priority_waiters.sv
test/message_queue_with_priority_waiters_tb.sv
